// ----- rtl/rti_pkg.sv -----
// rti_pkg: widths, register indexes and transaction types for the ray/triangle test
// used by ray_triangle_intersect and rti_divider; no dependencies
package rti_pkg;

   // field formats
   localparam int COORD_BITS = 24;
   localparam int FRAC_BITS  = 12;
   localparam int BARY_FRAC  = 16;
   localparam int BARY_W     = 17;
   localparam int DIST_W     = 24;

   // datapath widths, exact for any coordinate width
   localparam int EDGE_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * EDGE_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int LO_W    = CROSS_W / 2 + 1;
   localparam int HI_W    = CROSS_W - LO_W;
   localparam int MH_W    = EDGE_W + HI_W;
   localparam int ML_W    = EDGE_W + LO_W + 1;
   localparam int TERM_W  = EDGE_W + CROSS_W;
   localparam int DET_W   = TERM_W + 2;
   localparam int REM_W   = DET_W;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // configuration register indexes
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DIR_X    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

   // divider lanes
   localparam int LANES  = 3;
   localparam int LANE_U = 0;
   localparam int LANE_V = 1;
   localparam int LANE_T = 2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] vert_a_x;
      logic signed [COORD_BITS-1:0] vert_a_y;
      logic signed [COORD_BITS-1:0] vert_a_z;
      logic signed [COORD_BITS-1:0] vert_b_x;
      logic signed [COORD_BITS-1:0] vert_b_y;
      logic signed [COORD_BITS-1:0] vert_b_z;
      logic signed [COORD_BITS-1:0] vert_c_x;
      logic signed [COORD_BITS-1:0] vert_c_y;
      logic signed [COORD_BITS-1:0] vert_c_z;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic              degenerate;
      logic [BARY_W-1:0] bary_u;
      logic [BARY_W-1:0] bary_v;
      logic [DIST_W-1:0] distance_t;
   } rsp_type;

   typedef struct packed {
      logic hit;
      logic degenerate;
      logic saturate;
   } div_tag_type;

   typedef struct packed {
      logic [REM_W-1:0]                  den;
      logic [LANES-1:0][REM_W-1:0]       rem;
      logic [LANES-1:0][DIST_W-1:0]      bits;
      div_tag_type                       tag;
   } div_in_type;

   typedef struct packed {
      logic [LANES-1:0][DIST_W-1:0] quo;
      div_tag_type                  tag;
   } div_out_type;

endpackage

// ----- rtl/rti_divider.sv -----
// rti_divider: pipelined restoring divider, three lanes sharing one denominator,
// one quotient bit per stage; depends on rti_pkg
module rti_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rti_pkg::div_in_type  in_data,
   output logic               out_valid,
   output rti_pkg::div_out_type out_data
);
   import rti_pkg::*;

   logic                         valid_ff [DIST_W];
   div_in_type                   work_ff  [DIST_W];
   logic [LANES-1:0][DIST_W-1:0] quo_ff   [DIST_W];

   for (genvar j = 0; j < DIST_W; j++) begin : g_stage
      logic                         prev_valid;
      div_in_type                   prev_work;
      logic [LANES-1:0][DIST_W-1:0] prev_quo;
      div_in_type                   work_in;
      logic [LANES-1:0][DIST_W-1:0] quo_in;

      // stage input: divider entry or previous stage
      if (j == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_work  = in_data;
         assign prev_quo   = '0;
      end else begin : g_next
         assign prev_valid = valid_ff[j-1];
         assign prev_work  = work_ff[j-1];
         assign prev_quo   = quo_ff[j-1];
      end

      // shift in the next numerator bit, subtract when it fits
      always_comb begin : step
         logic [REM_W-1:0] trial;
         trial   = '0;
         work_in = prev_work;
         quo_in  = prev_quo;
         for (int l = 0; l < LANES; l++) begin
            trial = {prev_work.rem[l][REM_W-2:0], prev_work.bits[l][DIST_W-1]};
            if (trial >= prev_work.den) begin
               work_in.rem[l] = trial - prev_work.den;
               quo_in[l]      = {prev_quo[l][DIST_W-2:0], 1'b1};
            end else begin
               work_in.rem[l] = trial;
               quo_in[l]      = {prev_quo[l][DIST_W-2:0], 1'b0};
            end
            work_in.bits[l] = {prev_work.bits[l][DIST_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else begin
            valid_ff[j] <= prev_valid;
         end
         work_ff[j] <= work_in;
         quo_ff[j]  <= quo_in;
      end
   end

   assign out_valid    = valid_ff[DIST_W-1];
   assign out_data.quo = quo_ff[DIST_W-1];
   assign out_data.tag = work_ff[DIST_W-1].tag;

endmodule

// ----- rtl/ray_triangle_intersect.sv -----
// ray_triangle_intersect: one triangle per cycle, result strobe registered through the
// 8 arithmetic stages, 24 divider stages and one output register
// throughput one transaction per cycle, busy is always low; rsp_valid cannot be stalled
// synchronous reset clears the pipeline valid bits and the ray registers to zero
// depends on rti_pkg and rti_divider
module ray_triangle_intersect (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  rti_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output rti_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [rti_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [rti_pkg::COORD_BITS-1:0]   csr_wdata
);
   import rti_pkg::*;

   localparam int NEXT1 [3] = '{1, 2, 0};
   localparam int NEXT2 [3] = '{2, 0, 1};
   localparam int DOT_DET = 0;
   localparam int DOT_T   = 1;
   localparam int DOT_U   = 2;
   localparam int DOT_NV  = 3;

   // ray registers
   logic signed [COORD_BITS-1:0] orig_ff [3];
   logic signed [COORD_BITS-1:0] dir_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            orig_ff[i] <= '0;
            dir_ff[i]  <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ORIGIN_X: orig_ff[0] <= csr_wdata;
            REG_ORIGIN_Y: orig_ff[1] <= csr_wdata;
            REG_ORIGIN_Z: orig_ff[2] <= csr_wdata;
            REG_DIR_X:    dir_ff[0]  <= csr_wdata;
            REG_DIR_Y:    dir_ff[1]  <= csr_wdata;
            REG_DIR_Z:    dir_ff[2]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 1: edges, origin offset and negated direction
   logic signed [COORD_BITS-1:0] va [3];
   logic signed [COORD_BITS-1:0] vb [3];
   logic signed [COORD_BITS-1:0] vc [3];
   logic                         s1_valid_ff;
   logic signed [EDGE_W-1:0]     e1_ff [3], e2_ff [3], sv_ff [3], nd_ff [3];

   assign va = '{req_data.vert_a_x, req_data.vert_a_y, req_data.vert_a_z};
   assign vb = '{req_data.vert_b_x, req_data.vert_b_y, req_data.vert_b_z};
   assign vc = '{req_data.vert_c_x, req_data.vert_c_y, req_data.vert_c_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      for (int i = 0; i < 3; i++) begin
         e1_ff[i] <= EDGE_W'(vb[i]) - EDGE_W'(va[i]);
         e2_ff[i] <= EDGE_W'(vc[i]) - EDGE_W'(va[i]);
         sv_ff[i] <= EDGE_W'(orig_ff[i]) - EDGE_W'(va[i]);
         nd_ff[i] <= -EDGE_W'(dir_ff[i]);
      end
   end

   // stage 2: cross product terms of e1 x e2 and nd x s
   logic                     s2_valid_ff;
   logic signed [EDGE_W-1:0] e1_2_ff [3], e2_2_ff [3], sv_2_ff [3], nd_2_ff [3];
   logic signed [PROD_W-1:0] pa_ff [3], pb_ff [3], qa_ff [3], qb_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      for (int i = 0; i < 3; i++) begin
         pa_ff[i] <= e1_ff[NEXT1[i]] * e2_ff[NEXT2[i]];
         pb_ff[i] <= e1_ff[NEXT2[i]] * e2_ff[NEXT1[i]];
         qa_ff[i] <= nd_ff[NEXT1[i]] * sv_ff[NEXT2[i]];
         qb_ff[i] <= nd_ff[NEXT2[i]] * sv_ff[NEXT1[i]];
      end
      e1_2_ff <= e1_ff;
      e2_2_ff <= e2_ff;
      sv_2_ff <= sv_ff;
      nd_2_ff <= nd_ff;
   end

   // stage 3: cross products
   logic                      s3_valid_ff;
   logic signed [EDGE_W-1:0]  e1_3_ff [3], e2_3_ff [3], sv_3_ff [3], nd_3_ff [3];
   logic signed [CROSS_W-1:0] p_ff [3], q_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      for (int i = 0; i < 3; i++) begin
         p_ff[i] <= CROSS_W'(pa_ff[i]) - CROSS_W'(pb_ff[i]);
         q_ff[i] <= CROSS_W'(qa_ff[i]) - CROSS_W'(qb_ff[i]);
      end
      e1_3_ff <= e1_2_ff;
      e2_3_ff <= e2_2_ff;
      sv_3_ff <= sv_2_ff;
      nd_3_ff <= nd_2_ff;
   end

   // stage 4: dot products split into high and low partial products
   logic signed [EDGE_W-1:0]  dot_vec   [4][3];
   logic signed [CROSS_W-1:0] dot_cross [4][3];
   logic                      s4_valid_ff;
   logic signed [MH_W-1:0]    mh_ff [4][3];
   logic signed [ML_W-1:0]    ml_ff [4][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dot_vec[DOT_DET][i]   = nd_3_ff[i];
         dot_cross[DOT_DET][i] = p_ff[i];
         dot_vec[DOT_T][i]     = sv_3_ff[i];
         dot_cross[DOT_T][i]   = p_ff[i];
         dot_vec[DOT_U][i]     = e2_3_ff[i];
         dot_cross[DOT_U][i]   = q_ff[i];
         dot_vec[DOT_NV][i]    = e1_3_ff[i];
         dot_cross[DOT_NV][i]  = q_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      for (int d = 0; d < 4; d++) begin
         for (int i = 0; i < 3; i++) begin
            mh_ff[d][i] <= dot_vec[d][i] * signed'(dot_cross[d][i][CROSS_W-1:LO_W]);
            ml_ff[d][i] <= dot_vec[d][i] * signed'({1'b0, dot_cross[d][i][LO_W-1:0]});
         end
      end
   end

   // stage 5: recombine partial products
   logic                     s5_valid_ff;
   logic signed [TERM_W-1:0] term_ff [4][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      for (int d = 0; d < 4; d++) begin
         for (int i = 0; i < 3; i++) begin
            term_ff[d][i] <= (TERM_W'(mh_ff[d][i]) <<< LO_W) + TERM_W'(ml_ff[d][i]);
         end
      end
   end

   // stage 6: determinant and the three numerators
   logic                    s6_valid_ff;
   logic signed [DET_W-1:0] sum_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
      for (int d = 0; d < 4; d++) begin
         sum_ff[d] <= DET_W'(term_ff[d][0]) + DET_W'(term_ff[d][1]) + DET_W'(term_ff[d][2]);
      end
   end

   // stage 7: make the determinant positive with the numerator signs to match, flag a zero determinant
   logic                    det_neg;
   logic                    s7_valid_ff;
   logic                    degen_ff;
   logic [DET_W-1:0]        det_abs_ff;
   logic signed [DET_W-1:0] nu_ff, nv_ff, nt_ff;

   assign det_neg = sum_ff[DOT_DET][DET_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= s6_valid_ff;
      end
      degen_ff   <= (sum_ff[DOT_DET] == '0);
      det_abs_ff <= det_neg ? $unsigned(-sum_ff[DOT_DET]) : $unsigned(sum_ff[DOT_DET]);
      nu_ff      <= det_neg ? -sum_ff[DOT_U] : sum_ff[DOT_U];
      nv_ff      <= det_neg ? sum_ff[DOT_NV] : -sum_ff[DOT_NV];
      nt_ff      <= det_neg ? -sum_ff[DOT_T] : sum_ff[DOT_T];
   end

   // stage 8: inside test, saturation test, divider operands
   logic signed [DET_W:0] sum_uv;
   logic                  outside;
   logic                  saturate;
   logic                  s8_valid_ff;
   div_in_type            div_in;
   div_in_type            div_in_ff;

   always_comb begin
      sum_uv   = (DET_W+1)'(nu_ff) + (DET_W+1)'(nv_ff);
      outside  = nu_ff[DET_W-1] || nv_ff[DET_W-1] || nt_ff[DET_W-1] ||
                 (signed'({1'b0, det_abs_ff}) < sum_uv);
      saturate = {{FRAC_BITS{1'b0}}, $unsigned(nt_ff)} >=
                 {det_abs_ff, {FRAC_BITS{1'b0}}};
      div_in.den              = det_abs_ff;
      div_in.rem[LANE_U]      = $unsigned(nu_ff) >> (DIST_W - BARY_FRAC);
      div_in.bits[LANE_U]     = {nu_ff[DIST_W-BARY_FRAC-1:0], {BARY_FRAC{1'b0}}};
      div_in.rem[LANE_V]      = $unsigned(nv_ff) >> (DIST_W - BARY_FRAC);
      div_in.bits[LANE_V]     = {nv_ff[DIST_W-BARY_FRAC-1:0], {BARY_FRAC{1'b0}}};
      div_in.rem[LANE_T]      = $unsigned(nt_ff) >> (DIST_W - FRAC_BITS);
      div_in.bits[LANE_T]     = {nt_ff[DIST_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      div_in.tag.hit          = !degen_ff && !outside;
      div_in.tag.degenerate   = degen_ff;
      div_in.tag.saturate     = saturate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else begin
         s8_valid_ff <= s7_valid_ff;
      end
      div_in_ff <= div_in;
   end

   // quotients for u, v and t
   logic        div_valid;
   div_out_type div_out;

   rti_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s8_valid_ff),
      .in_data   (div_in_ff),
      .out_valid (div_valid),
      .out_data  (div_out)
   );

   // output register, hit, weights and distance zero on a miss
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   always_comb begin
      rsp_data_in            = '0;
      rsp_data_in.degenerate = div_out.tag.degenerate;
      if (div_out.tag.hit) begin
         rsp_data_in.hit        = 1'b1;
         rsp_data_in.bary_u     = div_out.quo[LANE_U][BARY_W-1:0];
         rsp_data_in.bary_v     = div_out.quo[LANE_V][BARY_W-1:0];
         rsp_data_in.distance_t = div_out.tag.saturate ? DIST_MAX : div_out.quo[LANE_T];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // a hit never comes from a zero determinant
   a_hit_not_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.hit && rsp_data.degenerate))
      else $error("hit reported on a degenerate triangle");

   // a miss carries zero weights and distance
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |->
         (rsp_data.bary_u == '0 && rsp_data.bary_v == '0 && rsp_data.distance_t == '0))
      else $error("nonzero result fields on a miss");

   // truncated weights of a hit never sum above one
   a_bary_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |->
         ((BARY_W+1)'(rsp_data.bary_u) + (BARY_W+1)'(rsp_data.bary_v) <=
          (BARY_W+1)'(1) << BARY_FRAC))
      else $error("barycentric weights exceed one");

   // a saturated distance of a hit reaches the output register as DIST_MAX
   a_sat_hit: assert property (@(posedge clock) disable iff (reset)
      (div_valid && div_out.tag.hit && div_out.tag.saturate) |=>
         (rsp_valid && rsp_data.distance_t == DIST_MAX))
      else $error("saturated distance lost at the output register");
`endif

endmodule

// ----- test/tb_ray_triangle_intersect.sv -----
// tb_ray_triangle_intersect: self-checking bench for the ray/triangle intersection block
// drives triangles against several ray settings and compares each result with a local
// cramer-rule model; depends on rti_pkg and ray_triangle_intersect
module tb_ray_triangle_intersect;
   timeunit 1ns;
   timeprecision 1ps;
   import rti_pkg::*;

   localparam int PERIOD     = 20;
   localparam int LATENCY    = 32;
   localparam int IDLE_LIMIT = 5000;
   localparam int MAX_GAP    = 13;
   localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
   localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] ONE   = 1 << FRAC_BITS;

   typedef logic signed [127:0] wide_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [REG_IDX_W-1:0]   csr_index;
   logic [COORD_BITS-1:0]  csr_wdata;

   // ray copy: origin x/y/z then direction x/y/z
   logic signed [COORD_BITS-1:0] ray_shadow [6];

   req_type  triangle_q [$];
   rsp_type  hit_result_q [$];
   int       mismatches;
   int       idle_cycles;
   int       gap_left;
   bit       burst_mode;
   int       sent_count;

   ray_triangle_intersect dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(PERIOD/2) clock = ~clock;
   end

   // 3x3 determinant with columns p, q, r
   function automatic wide_type det3(wide_type p[3], wide_type q[3], wide_type r[3]);
      wide_type cx, cy, cz;
      cx = q[1]*r[2] - q[2]*r[1];
      cy = q[2]*r[0] - q[0]*r[2];
      cz = q[0]*r[1] - q[1]*r[0];
      return p[0]*cx + p[1]*cy + p[2]*cz;
   endfunction

   // expected intersection result for one triangle against the current ray
   function automatic rsp_type intersect_predict(req_type tri_in);
      wide_type a[3], b[3], c[3], e1[3], e2[3], nd[3], s[3];
      wide_type det, nu, nv, nt, qt;
      rsp_type  r;
      r = '0;
      a[0] = tri_in.vert_a_x; a[1] = tri_in.vert_a_y; a[2] = tri_in.vert_a_z;
      b[0] = tri_in.vert_b_x; b[1] = tri_in.vert_b_y; b[2] = tri_in.vert_b_z;
      c[0] = tri_in.vert_c_x; c[1] = tri_in.vert_c_y; c[2] = tri_in.vert_c_z;
      for (int i = 0; i < 3; i++) begin
         e1[i] = b[i] - a[i];
         e2[i] = c[i] - a[i];
         nd[i] = -wide_type'(ray_shadow[3+i]);
         s[i]  = wide_type'(ray_shadow[i]) - a[i];
      end
      det = det3(e1, e2, nd);
      if (det == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      nu = det3(s, e2, nd);
      nv = det3(e1, s, nd);
      nt = det3(e1, e2, s);
      if (det < 0) begin
         det = -det; nu = -nu; nv = -nv; nt = -nt;
      end
      if (nu < 0 || nv < 0 || nt < 0) return r;
      if (det < nu + nv) return r;
      r.hit    = 1'b1;
      r.bary_u = BARY_W'((nu <<< BARY_FRAC) / det);
      r.bary_v = BARY_W'((nv <<< BARY_FRAC) / det);
      qt = (nt <<< FRAC_BITS) / det;
      r.distance_t = (qt > wide_type'(DIST_MAX)) ? DIST_MAX : DIST_W'(qt);
      return r;
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      mismatches++;
   endtask

   function automatic logic signed [COORD_BITS-1:0] clamp(wide_type v);
      if (v > wide_type'(C_MAX)) return C_MAX;
      if (v < wide_type'(C_MIN)) return C_MIN;
      return v[COORD_BITS-1:0];
   endfunction

   function automatic logic signed [COORD_BITS-1:0] rnd_span(int span);
      return clamp(wide_type'($urandom_range(0, 2*span)) - span);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] rnd_full();
      return COORD_BITS'($urandom());
   endfunction

   function automatic req_type make_tri(wide_type ax, wide_type ay, wide_type az,
                                        wide_type bx, wide_type by, wide_type bz,
                                        wide_type cx, wide_type cy, wide_type cz);
      req_type t;
      t.vert_a_x = clamp(ax); t.vert_a_y = clamp(ay); t.vert_a_z = clamp(az);
      t.vert_b_x = clamp(bx); t.vert_b_y = clamp(by); t.vert_b_z = clamp(bz);
      t.vert_c_x = clamp(cx); t.vert_c_y = clamp(cy); t.vert_c_z = clamp(cz);
      return t;
   endfunction

   // triangle placed around a point on the ray so many of them are hit
   function automatic req_type aimed_tri();
      wide_type p[3];
      int       span;
      wide_type k;
      req_type  t;
      k = $urandom_range(0, 8*ONE);
      if ($urandom_range(0, 7) == 0) k = -k;
      case ($urandom_range(0, 3))
         0: span = 256;
         1: span = 4096;
         2: span = 65536;
         default: span = 1 << 21;
      endcase
      for (int i = 0; i < 3; i++)
         p[i] = wide_type'(ray_shadow[i]) + ((wide_type'(ray_shadow[3+i]) * k) >>> FRAC_BITS);
      t = make_tri(p[0] + rnd_span(span), p[1] + rnd_span(span), p[2] + rnd_span(span),
                   p[0] + rnd_span(span), p[1] + rnd_span(span), p[2] + rnd_span(span),
                   p[0] + rnd_span(span), p[1] + rnd_span(span), p[2] + rnd_span(span));
      return t;
   endfunction

   function automatic req_type noise_tri();
      req_type t;
      t = {rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(),
           rnd_full(), rnd_full(), rnd_full()};
      return t;
   endfunction

   // driver: feeds queued triangles with random gaps, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
         gap_left = 0;
      end else begin
         if (start && !busy)
            hit_result_q.push_back(intersect_predict(req_data));
         if (start && busy) begin
            // hold the transaction until accepted
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (triangle_q.size() > 0) begin
            req_data <= triangle_q.pop_front();
            start    <= 1'b1;
            sent_count++;
            if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;
            gap_left = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: compares each result with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (hit_result_q.size() == 0) begin
            $display("unexpected result at %0t", $realtime);
            mismatches++;
         end else begin
            want = hit_result_q.pop_front();
            if (rsp_data.hit !== want.hit) report("hit", rsp_data.hit, want.hit);
            if (rsp_data.degenerate !== want.degenerate)
               report("degenerate", rsp_data.degenerate, want.degenerate);
            if (rsp_data.bary_u !== want.bary_u) report("bary_u", rsp_data.bary_u, want.bary_u);
            if (rsp_data.bary_v !== want.bary_v) report("bary_v", rsp_data.bary_v, want.bary_v);
            if (rsp_data.distance_t !== want.distance_t)
               report("distance_t", rsp_data.distance_t, want.distance_t);
         end
      end
   end

   // watchdog on cycles without any accepted transaction or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [COORD_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx <= REG_DIR_Z) ray_shadow[idx] = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_ray(logic [COORD_BITS-1:0] ox, logic [COORD_BITS-1:0] oy,
                          logic [COORD_BITS-1:0] oz, logic [COORD_BITS-1:0] dx,
                          logic [COORD_BITS-1:0] dy, logic [COORD_BITS-1:0] dz);
      csr_write(REG_ORIGIN_X, ox);
      csr_write(REG_ORIGIN_Y, oy);
      csr_write(REG_ORIGIN_Z, oz);
      csr_write(REG_DIR_X, dx);
      csr_write(REG_DIR_Y, dy);
      csr_write(REG_DIR_Z, dz);
   endtask

   // wait until every queued triangle has its result, then let the pipe drain
   task automatic drain();
      while (triangle_q.size() > 0 || start || gap_left > 0 || hit_result_q.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++)
         triangle_q.push_back(($urandom_range(0, 9) < 7) ? aimed_tri() : noise_tri());
   endtask

   // stimulus sequence
   initial begin
      mismatches = 0;
      sent_count = 0;
      burst_mode = 1'b0;
      start      = 1'b0;
      req_data   = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      for (int i = 0; i < 6; i++) ray_shadow[i] = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset ray has zero direction: everything is degenerate
      triangle_q.push_back(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
      triangle_q.push_back(noise_tri());
      drain();

      // ray along +z from z=-10
      set_ray(0, 0, COORD_BITS'(-10*ONE), 0, 0, ONE);
      triangle_q.push_back(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0));          // vertex a
      triangle_q.push_back(make_tri(-ONE, 0, 0, 0, 0, 0, 0, ONE, 0));         // vertex b
      triangle_q.push_back(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, 0, 0));   // vertex c
      triangle_q.push_back(make_tri(-ONE, 0, 0, ONE, 0, 0, 0, ONE, 0));       // on edge
      triangle_q.push_back(make_tri(-ONE, -ONE, 0, 3*ONE, -ONE, 0, -ONE, 3*ONE, 0));
      triangle_q.push_back(make_tri(ONE, ONE, 0, 2*ONE, ONE, 0, ONE, 2*ONE, 0)); // miss
      triangle_q.push_back(make_tri(-ONE, -ONE, -20*ONE, 3*ONE, -ONE, -20*ONE,
                                    -ONE, 3*ONE, -20*ONE));                     // behind
      triangle_q.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));              // degenerate
      triangle_q.push_back(make_tri(-ONE, 0, 0, ONE, 0, 0, 0, 0, ONE));       // contains ray
      triangle_q.push_back(make_tri(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX,
                                    C_MIN, C_MAX, C_MAX));
      triangle_q.push_back(make_tri(C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN,
                                    C_MAX, C_MIN, C_MIN));
      triangle_q.push_back(make_tri(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                                    C_MIN, C_MAX, C_MIN));
      drain();

      // tiny direction and a far plane: t saturates; unused indexes ignored
      set_ray(0, 0, C_MIN, 0, 0, 1);
      csr_write(REG_SPARE_6, C_MAX);
      csr_write(REG_SPARE_7, 24'h5a5a5a);
      triangle_q.push_back(make_tri(-ONE, -ONE, C_MAX, 3*ONE, -ONE, C_MAX,
                                    -ONE, 3*ONE, C_MAX));
      triangle_q.push_back(make_tri(-ONE, -ONE, 0, 3*ONE, -ONE, 0, -ONE, 3*ONE, 0));
      random_phase(60);
      drain();

      // randomized rays, extremes among them
      set_ray(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
      random_phase(80);
      drain();
      set_ray(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
      random_phase(80);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         if (ph % 2 == 0)
            set_ray(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full());
         else
            set_ray(rnd_span(1 << 18), rnd_span(1 << 18), rnd_span(1 << 18),
                    rnd_span(1 << 14), rnd_span(1 << 14), rnd_span(1 << 14));
         random_phase(65);
         drain();
      end

      if (mismatches == 0 && hit_result_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- ray_triangle_intersect.f -----
rtl/rti_pkg.sv
rtl/rti_divider.sv
rtl/ray_triangle_intersect.sv
test/tb_ray_triangle_intersect.sv
